FILE: hdl/adm_pkg.sv
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types and constants of the audio coprocessor register window.
// ----------------------------------------------------------------------------
package adm_pkg;

    localparam int MAIL_DEPTH_DEF = 8;

    // item function codes
    localparam logic [2:0] FN_READ      = 3'd0;
    localparam logic [2:0] FN_WRITE     = 3'd1;
    localparam logic [2:0] FN_DMA_TICK  = 3'd2;
    localparam logic [2:0] FN_DMA_START = 3'd3;
    localparam logic [2:0] FN_TIME_TICK = 3'd4;

    // register offsets
    localparam logic [8:0] OFF_MAILIN_HI  = 9'h000;
    localparam logic [8:0] OFF_MAILIN_LO  = 9'h002;
    localparam logic [8:0] OFF_MAILOUT_HI = 9'h004;
    localparam logic [8:0] OFF_MAILOUT_LO = 9'h006;
    localparam logic [8:0] OFF_CONTROL    = 9'h00A;
    localparam logic [8:0] OFF_AR_COUNT   = 9'h028;
    localparam logic [8:0] OFF_DMA_SRC_HI = 9'h030;
    localparam logic [8:0] OFF_DMA_SRC_LO = 9'h032;
    localparam logic [8:0] OFF_DMA_CTRL   = 9'h036;
    localparam logic [8:0] OFF_DMA_LEFT   = 9'h03A;

    // control/status bits
    localparam logic [15:0] ST_RES      = 16'h0001;
    localparam logic [15:0] ST_HALT     = 16'h0004;
    localparam logic [15:0] ST_AID      = 16'h0008;
    localparam logic [15:0] ST_AR       = 16'h0020;
    localparam logic [15:0] ST_DSP      = 16'h0080;
    localparam logic [15:0] ST_DMAST    = 16'h0200;
    localparam logic [15:0] ST_INITCODE = 16'h0400;
    localparam logic [15:0] ST_INIT     = 16'h0800;
    localparam logic [15:0] ST_W1C      = ST_AID | ST_AR | ST_DSP;
    localparam logic [15:0] ST_RESET    = ST_HALT | ST_INIT;

    // mail words
    localparam logic [31:0] MAIL_ROM         = 32'h8071FEED;
    localparam logic [31:0] MAIL_INITUC      = 32'h80544348;
    localparam logic [31:0] MAIL_TASK_INIT   = 32'hDCD10000;
    localparam logic [31:0] MAIL_TASK_RESUME = 32'hDCD10001;
    localparam logic [31:0] MAIL_TASK_YIELD  = 32'hDCD10002;
    localparam logic [31:0] MAIL_TASK_SYNC   = 32'hDCD10004;
    localparam logic [15:0] MAIL_ECHO_HI     = 16'hFEEE;
    localparam logic [15:0] MAIL_BOOT_HI     = 16'h80F3;
    localparam logic [15:0] MAIL_LIST_HI     = 16'hBABE;
    localparam logic [31:0] CMD_SET_SRC      = 32'h80F3A001;
    localparam logic [31:0] CMD_SET_LEN      = 32'h80F3A002;
    localparam logic [31:0] CMD_START        = 32'h80F3D001;
    localparam logic [31:0] CMD_RESUME       = 32'hCDD10000;
    localparam logic [31:0] CMD_RESELECT     = 32'hCDD10002;
    localparam logic [31:0] MAIL_CLR_TOP     = 32'h7FFFFFFF;

    localparam logic [15:0] DMA_ENABLE   = 16'h8000;
    localparam logic [7:0]  HOLD_DEF     = 8'd130;
    localparam logic [31:0] DMA_BLOCK_SZ = 32'd32;

    typedef struct packed {
        logic             pop;
        logic             clear;
        logic [1:0]       posts;
        logic [1:0]       irq;
        logic [1:0][31:0] mail;
    } t_mb_cmd;

    typedef struct packed {
        logic        nonempty;
        logic [31:0] head;
        logic        head_def;
        logic        dsp_set;
    } t_mb_stat;

endpackage

FILE: hdl/adm_mbox.sv
// ----------------------------------------------------------------------------
// adm_mbox
// Outgoing mail queue with a deferred-interrupt flag per entry.
// ----------------------------------------------------------------------------
module adm_mbox #(
    parameter int Depth = adm_pkg::MAIL_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  adm_pkg::t_mb_cmd  i_cmd,
    output adm_pkg::t_mb_stat o_stat
);
    import adm_pkg::*;

    localparam int IW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int FW = $clog2(Depth + 1);
    localparam int SW = FW + 1;

    logic [31:0]      r_slots [Depth];
    logic [31:0]      n_slots [Depth];
    logic [Depth-1:0] r_def, n_def;
    logic [IW-1:0]    r_front, n_front;
    logic [FW-1:0]    r_fill, n_fill;
    logic [SW-1:0]    s_sum;
    logic [IW-1:0]    s_slot;
    logic             s_dsp;

    always_comb begin
        n_slots = r_slots;
        n_def   = r_def;
        n_front = r_front;
        n_fill  = r_fill;
        s_dsp   = 1'b0;
        s_sum   = '0;
        s_slot  = '0;
        if (i_cmd.pop) begin
            n_front = (r_front == IW'(Depth - 1)) ? '0 : r_front + 1'b1;
            n_fill  = r_fill - 1'b1;
        end
        if (i_cmd.clear) begin
            n_front = '0;
            n_fill  = '0;
        end
        for (int k = 0; k < 2; k++) begin
            if ((2'(k) < i_cmd.posts) && (n_fill < FW'(Depth))) begin
                if (i_cmd.irq[k]) begin
                    if (n_fill == '0) begin
                        s_dsp = 1'b1;
                    end else begin
                        n_def[n_front] = 1'b1;
                    end
                end
                s_sum  = SW'(n_front) + SW'(n_fill);
                s_slot = (s_sum >= SW'(Depth)) ? IW'(s_sum - SW'(Depth)) : IW'(s_sum);
                n_slots[s_slot] = i_cmd.mail[k];
                n_def[s_slot]   = 1'b0;
                n_fill          = n_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_fill  <= FW'(1);
            r_def   <= '0;
        end else begin
            r_front <= n_front;
            r_fill  <= n_fill;
            r_def   <= n_def;
        end
    end

    // greeting sits in slot zero out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots[0] <= MAIL_ROM;
        end else begin
            r_slots <= n_slots;
        end
    end

    assign o_stat.nonempty = (r_fill != '0);
    assign o_stat.head     = r_slots[r_front];
    assign o_stat.head_def = r_def[r_front];
    assign o_stat.dsp_set  = s_dsp;

endmodule

FILE: hdl/audio_dsp_mailbox_and_dma_regs.sv
// Register window of the audio coprocessor. Every item (bus read, bus write,
// DMA block tick, DMA start, time tick) passes through the input register
// and then through the update logic into the result register. One item is
// accepted per clock while results are taken; a stalled result holds the
// pipeline. The outgoing mail queue is MAIL_DEPTH entries of flip-flops, and
// up to two mails may be posted by one item. The APB port writes the
// init-code hold count at addresses 0 to 3.
// ----------------------------------------------------------------------------
// audio_dsp_mailbox_and_dma_regs
// Control/status, mailboxes, boot command decode and audio DMA counters.
// ----------------------------------------------------------------------------
module audio_dsp_mailbox_and_dma_regs #(
    parameter int MAIL_DEPTH = adm_pkg::MAIL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [8:0]  i_reg_offset,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_read_data,
    output logic        o_irq_line,
    output logic        o_fetch_valid,
    output logic [31:0] o_fetch_addr,
    output logic        o_cmdlist_valid,
    output logic [31:0] o_cmdlist_addr,
    output logic [15:0] o_cmdlist_words,
    output logic        o_ucode_boot_valid,
    output logic [31:0] o_ucode_src_addr,
    output logic [15:0] o_ucode_length,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adm_pkg::*;

    // input register
    logic        r_v1;
    logic [2:0]  r_func;
    logic [8:0]  r_off;
    logic [15:0] r_wdata;
    logic        s_adv;

    // state
    logic [7:0]  r_hold;
    logic [15:0] r_cs, n_cs;
    logic [31:0] r_inmail, n_inmail;
    logic [31:0] r_vis, n_vis;
    logic        r_gated, n_gated;
    logic [31:0] r_pend, n_pend;
    logic        r_ucact, n_ucact;
    logic        r_listexp, n_listexp;
    logic [15:0] r_listlen, n_listlen;
    logic [31:0] r_bsrc, n_bsrc;
    logic [15:0] r_blen, n_blen;
    logic [15:0] r_dmactl, n_dmactl;
    logic [14:0] r_left, n_left;
    logic [31:0] r_dsrc, n_dsrc;
    logic [31:0] r_cur, n_cur;
    logic [7:0]  r_icd, n_icd;

    // result register
    logic        r_ov;
    logic [15:0] r_rd, n_rd;
    logic        r_irq;
    logic        r_fv, n_fv;
    logic [31:0] r_fa, n_fa;
    logic        r_clv, n_clv;
    logic [31:0] r_cla, n_cla;
    logic [15:0] r_clw, n_clw;
    logic        r_ucv, n_ucv;
    logic [31:0] r_uca, n_uca;
    logic [15:0] r_ucl, n_ucl;

    t_mb_cmd     s_cmd, s_mb_cmd;
    t_mb_stat    s_stat;
    logic [31:0] s_mail;
    logic        s_pop_ok;
    logic        s_was_h, s_was_i;
    logic [15:0] s_ctl;
    logic [15:0] s_cs_upd;

    assign s_adv      = r_v1 && (!r_ov || i_out_ready);
    assign o_in_ready = !r_v1 || s_adv;
    assign s_mail     = {r_inmail[31:16], r_wdata};
    assign s_pop_ok   = !r_gated && s_stat.nonempty;
    assign s_mb_cmd   = s_adv ? s_cmd : '0;
    // a mail posted with its interrupt flag into an empty queue raises the DSP status bit at once
    assign s_cs_upd   = s_stat.dsp_set ? (n_cs | ST_DSP) : n_cs;

    adm_mbox #(.Depth(MAIL_DEPTH)) u_mbox (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (s_mb_cmd),
        .o_stat (s_stat)
    );

    always_comb begin
        n_cs = r_cs; n_inmail = r_inmail; n_vis = r_vis; n_gated = r_gated;
        n_pend = r_pend; n_ucact = r_ucact; n_listexp = r_listexp;
        n_listlen = r_listlen; n_bsrc = r_bsrc; n_blen = r_blen;
        n_dmactl = r_dmactl; n_left = r_left; n_dsrc = r_dsrc; n_cur = r_cur;
        n_icd = r_icd;
        n_rd = '0; n_fv = 1'b0; n_fa = '0; n_clv = 1'b0; n_cla = '0; n_clw = '0;
        n_ucv = 1'b0; n_uca = '0; n_ucl = '0;
        s_cmd = '0;
        s_was_h = (r_cs & ST_HALT) != '0;
        s_was_i = (r_cs & ST_INIT) != '0;
        s_ctl = '0;
        case (r_func)
            FN_READ: begin
                unique case (r_off)
                    OFF_CONTROL: begin
                        if (((r_cs & ST_INITCODE) != '0) && r_icd == '0) begin
                            n_cs = r_cs & ~ST_INITCODE;
                        end
                        n_rd = n_cs;
                    end
                    OFF_DMA_CTRL:   n_rd = r_dmactl;
                    OFF_DMA_LEFT:   n_rd = (r_left != '0) ? {1'b0, r_left - 1'b1} : '0;
                    OFF_DMA_SRC_HI: n_rd = r_dsrc[31:16];
                    OFF_DMA_SRC_LO: n_rd = r_dsrc[15:0];
                    OFF_MAILOUT_HI: begin
                        if (s_pop_ok) begin
                            n_vis = s_stat.head;
                        end
                        n_rd = n_vis[31:16];
                    end
                    OFF_MAILOUT_LO: begin
                        if (s_pop_ok) begin
                            n_vis = s_stat.head;
                            s_cmd.pop = 1'b1;
                            if (s_stat.head_def) begin
                                n_cs = r_cs | ST_DSP;
                            end
                        end
                        n_vis = n_vis & MAIL_CLR_TOP;
                        n_rd = n_vis[15:0];
                    end
                    default: n_rd = '0;
                endcase
            end
            FN_WRITE: begin
                unique case (r_off)
                    OFF_CONTROL: begin
                        s_ctl = (r_wdata & ~(ST_W1C | ST_DMAST | ST_RES | ST_INITCODE))
                              | (r_cs & ST_W1C & ~r_wdata)
                              | (r_cs & (ST_DMAST | ST_INITCODE));
                        n_cs = s_ctl;
                        if (s_was_h != ((s_ctl & ST_HALT) != '0)) begin
                            n_gated = (s_ctl & ST_HALT) != '0;
                        end
                        if ((r_wdata & ST_RES) != '0) begin
                            n_dmactl = '0;
                            n_left = '0;
                            n_ucact = 1'b0; n_pend = '0; n_listexp = 1'b0;
                            s_cmd.clear = 1'b1; s_cmd.posts = 2'd1;
                            s_cmd.mail[0] = MAIL_ROM;
                        end else if (s_was_i && ((s_ctl & ST_INIT) == '0)) begin
                            n_ucact = 1'b0; n_pend = '0; n_listexp = 1'b0;
                            s_cmd.clear = 1'b1; s_cmd.posts = 2'd1;
                            s_cmd.mail[0] = MAIL_INITUC;
                            n_cs = s_ctl | ST_INITCODE;
                            n_icd = r_hold;
                        end
                    end
                    OFF_MAILIN_HI: n_inmail = {r_wdata, r_inmail[15:0]};
                    OFF_MAILIN_LO: begin
                        n_inmail = s_mail;
                        if (!r_ucact) begin
                            if (r_pend == '0) begin
                                if (s_mail[31:16] == MAIL_BOOT_HI) begin
                                    n_pend = s_mail;
                                end else begin
                                    s_cmd.posts = 2'd1;
                                    s_cmd.mail[0] = {MAIL_ECHO_HI, s_mail[15:0]};
                                end
                            end else begin
                                n_pend = '0;
                                if (r_pend == CMD_SET_SRC) begin
                                    n_bsrc = s_mail;
                                end else if (r_pend == CMD_SET_LEN) begin
                                    n_blen = s_mail[15:0];
                                end else if (r_pend == CMD_START) begin
                                    n_ucact = 1'b1;
                                    n_ucv = 1'b1; n_uca = r_bsrc; n_ucl = r_blen;
                                    s_cmd.posts = 2'd1; s_cmd.irq = 2'b01;
                                    s_cmd.mail[0] = MAIL_TASK_INIT;
                                end
                            end
                        end else if (r_listexp) begin
                            n_listexp = 1'b0;
                            n_clv = 1'b1; n_cla = s_mail; n_clw = r_listlen;
                            s_cmd.posts = 2'd2; s_cmd.irq = 2'b11;
                            s_cmd.mail[0] = MAIL_TASK_SYNC;
                            s_cmd.mail[1] = MAIL_TASK_YIELD;
                        end else if (s_mail[31:16] == MAIL_LIST_HI) begin
                            n_listexp = 1'b1;
                            n_listlen = s_mail[15:0];
                        end else if (s_mail == CMD_RESUME) begin
                            s_cmd.posts = 2'd1; s_cmd.irq = 2'b01;
                            s_cmd.mail[0] = MAIL_TASK_RESUME;
                        end else if (s_mail == CMD_RESELECT) begin
                            n_ucact = 1'b0; n_pend = '0; n_listexp = 1'b0;
                            s_cmd.clear = 1'b1; s_cmd.posts = 2'd1;
                            s_cmd.mail[0] = MAIL_ROM;
                        end
                    end
                    OFF_DMA_CTRL: begin
                        n_dmactl = r_wdata;
                        if (((r_dmactl & DMA_ENABLE) == '0) && ((r_wdata & DMA_ENABLE) != '0)) begin
                            n_cur = r_dsrc;
                            n_left = r_wdata[14:0];
                        end
                    end
                    OFF_DMA_SRC_HI: n_dsrc = {r_wdata, r_dsrc[15:0]};
                    OFF_DMA_SRC_LO: n_dsrc = {r_dsrc[31:16], r_wdata};
                    OFF_AR_COUNT:   n_cs = r_cs | ST_AR;
                    default: ;
                endcase
            end
            FN_DMA_TICK: begin
                if ((r_dmactl & DMA_ENABLE) != '0) begin
                    n_fv = 1'b1;
                    n_fa = r_cur;
                    if (r_left != '0) begin
                        n_left = r_left - 1'b1;
                        n_cur = r_cur + DMA_BLOCK_SZ;
                    end
                    // reload when the count runs out
                    if (n_left == '0) begin
                        n_cur = r_dsrc;
                        n_left = r_dmactl[14:0];
                        n_cs = r_cs | ST_AID;
                    end
                end
            end
            FN_DMA_START: n_cs = r_cs | ST_AID;
            FN_TIME_TICK: begin
                if (r_icd != '0) begin
                    n_icd = r_icd - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_ov <= 1'b0; r_hold <= HOLD_DEF;
            r_cs <= ST_RESET; r_inmail <= '0; r_vis <= '0; r_gated <= 1'b0;
            r_pend <= '0; r_ucact <= 1'b0; r_listexp <= 1'b0; r_listlen <= '0;
            r_bsrc <= '0; r_blen <= '0; r_dmactl <= '0; r_left <= '0;
            r_dsrc <= '0; r_cur <= '0; r_icd <= '0;
        end else begin
            if (psel && penable && pwrite && !paddr[2]) begin
                r_hold <= pwdata[7:0];
            end
            if (o_in_ready) begin
                r_v1 <= i_in_valid;
            end
            if (s_adv) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (s_adv) begin
                r_cs <= s_cs_upd; r_inmail <= n_inmail; r_vis <= n_vis; r_gated <= n_gated;
                r_pend <= n_pend; r_ucact <= n_ucact; r_listexp <= n_listexp;
                r_listlen <= n_listlen; r_bsrc <= n_bsrc; r_blen <= n_blen;
                r_dmactl <= n_dmactl; r_left <= n_left; r_dsrc <= n_dsrc;
                r_cur <= n_cur; r_icd <= n_icd;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_func <= i_func; r_off <= i_reg_offset; r_wdata <= i_write_data;
        end
        if (s_adv) begin
            r_rd <= n_rd;
            r_irq <= ((s_cs_upd >> 1) & s_cs_upd & ST_W1C) != '0;
            r_fv <= n_fv; r_fa <= n_fa;
            r_clv <= n_clv; r_cla <= n_cla; r_clw <= n_clw;
            r_ucv <= n_ucv; r_uca <= n_uca; r_ucl <= n_ucl;
        end
    end

    assign o_out_valid        = r_ov;
    assign o_read_data        = r_rd;
    assign o_irq_line         = r_irq;
    assign o_fetch_valid      = r_fv;
    assign o_fetch_addr       = r_fa;
    assign o_cmdlist_valid    = r_clv;
    assign o_cmdlist_addr     = r_cla;
    assign o_cmdlist_words    = r_clw;
    assign o_ucode_boot_valid = r_ucv;
    assign o_ucode_src_addr   = r_uca;
    assign o_ucode_length     = r_ucl;
    assign prdata             = paddr[2] ? '0 : {24'd0, r_hold};
    assign pready             = 1'b1;

    a_boot_cmd_idle_in_ucode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucact |-> (r_pend == '0))
        else $error("boot command pending while microcode runs");

    a_list_only_in_ucode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ucact |-> !r_listexp)
        else $error("command list expected without microcode");

    a_result_kinds_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_fv) |-> (!r_clv && !r_ucv))
        else $error("fetch transfer mixed with mail result");

endmodule
